/* rtl/core/apq_pkg.sv */
package apq_pkg;

    localparam int PRIO_W      = 16;
    localparam int DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF = 8;

    localparam logic signed [PRIO_W-1:0] PRIO_MAX = 16'sh7FFF;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_REM_MAX = 2'd1,
        KIND_REM_ID  = 2'd2,
        KIND_AGE     = 2'd3
    } apq_kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EMPTY     = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } apq_status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } apq_state_t;

    typedef struct packed {
        logic      sample;
        logic      upd;
        apq_kind_t kind;
    } apq_ctrl_t;

endpackage

/* rtl/core/aging_priority_queue.sv */
// Aging priority queue: up to DEPTH entries (id, priority), highest priority
// at the head, first-in first-out among equal priorities.
// Input channel s_*: one operation per transaction (insert, remove maximum,
// remove named id, age all). Result channel m_*: exactly one result per
// operation with removed id/priority, status and occupancy after the op.
// The input transaction registers the operation and the per-cell compare
// flags and moves to the execute state; the execute state then shifts the
// cell chain and loads the output register. No new operation is taken
// until the last one is done.
// s_ready is high only while idle and the output register is empty or
// being taken in the same cycle, so a stalled receiver holds the result
// and back-pressures the input after at most one pending result.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; cell contents are not cleared, only the fill count.
module aging_priority_queue #(
    parameter int DEPTH   = apq_pkg::DEPTH_DEF,
    parameter int ID_BITS = apq_pkg::ID_BITS_DEF,
    localparam int CW     = $clog2(DEPTH + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_kind,
    input  logic [ID_BITS-1:0]                 s_entry_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  s_prio,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ID_BITS-1:0]                 m_out_id,
    output logic signed [apq_pkg::PRIO_W-1:0]  m_out_prio,
    output logic [1:0]                         m_status,
    output logic [CW-1:0]                      m_occupancy
);

    localparam int PW = apq_pkg::PRIO_W;

    apq_pkg::apq_state_t state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    apq_pkg::apq_kind_t  kind_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic signed [PW-1:0] prio_reg;

    logic                 m_valid_reg, m_valid_next;
    logic [ID_BITS-1:0]   out_id_reg, out_id_next;
    logic signed [PW-1:0] out_prio_reg, out_prio_next;
    apq_pkg::apq_status_t status_reg, status_next;
    logic [CW-1:0]        occ_reg, occ_next;

    apq_pkg::apq_ctrl_t ctrl;
    logic accept, exec, full, empty, found, upd_ok;

    logic                 ge_w   [DEPTH];
    logic [ID_BITS-1:0]   id_w   [DEPTH];
    logic signed [PW-1:0] prio_w [DEPTH];
    logic                 pass_w [DEPTH+1];
    logic [ID_BITS-1:0]   seli_w [DEPTH+1];
    logic signed [PW-1:0] selp_w [DEPTH+1];

    assign s_ready = (state_reg == apq_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign exec    = (state_reg == apq_pkg::ST_EXEC);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign found   = pass_w[DEPTH];

    always_comb begin
        case (kind_reg)
            apq_pkg::KIND_INSERT:  upd_ok = !full;
            apq_pkg::KIND_REM_MAX: upd_ok = !empty;
            default:               upd_ok = 1'b1;
        endcase
    end

    assign ctrl.sample = accept;
    assign ctrl.upd    = exec && upd_ok;
    assign ctrl.kind   = kind_reg;

    assign pass_w[0] = 1'b0;
    assign seli_w[0] = '0;
    assign selp_w[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                 l_ge;
        logic [ID_BITS-1:0]   l_id, r_id;
        logic signed [PW-1:0] l_prio, r_prio;
        if (i == 0) begin : g_first
            assign l_ge   = 1'b1;
            assign l_id   = id_reg;
            assign l_prio = prio_reg;
        end else begin : g_mid
            assign l_ge   = ge_w[i-1];
            assign l_id   = id_w[i-1];
            assign l_prio = prio_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign r_id   = id_w[i];
            assign r_prio = prio_w[i];
        end else begin : g_inner
            assign r_id   = id_w[i+1];
            assign r_prio = prio_w[i+1];
        end
        apq_cell #(
            .IDX     (i),
            .DEPTH   (DEPTH),
            .ID_BITS (ID_BITS)
        ) u_cell (
            .aclk         (aclk),
            .ctrl         (ctrl),
            .count        (count_reg),
            .key_id       (s_entry_id),
            .key_prio     (s_prio),
            .new_id       (id_reg),
            .new_prio     (prio_reg),
            .left_ge      (l_ge),
            .left_id      (l_id),
            .left_prio    (l_prio),
            .right_id     (r_id),
            .right_prio   (r_prio),
            .pass_in      (pass_w[i]),
            .sel_in_id    (seli_w[i]),
            .sel_in_prio  (selp_w[i]),
            .ge           (ge_w[i]),
            .cur_id       (id_w[i]),
            .cur_prio     (prio_w[i]),
            .pass_out     (pass_w[i+1]),
            .sel_out_id   (seli_w[i+1]),
            .sel_out_prio (selp_w[i+1])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        m_valid_next  = m_valid_reg;
        out_id_next   = out_id_reg;
        out_prio_next = out_prio_reg;
        status_next   = status_reg;
        occ_next      = occ_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            apq_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = apq_pkg::ST_EXEC;
                end
            end
            apq_pkg::ST_EXEC: begin
                state_next    = apq_pkg::ST_IDLE;
                m_valid_next  = 1'b1;
                out_id_next   = '0;
                out_prio_next = '0;
                status_next   = apq_pkg::STAT_OK;
                case (kind_reg)
                    apq_pkg::KIND_INSERT: begin
                        if (full) begin
                            status_next = apq_pkg::STAT_FULL;
                        end else begin
                            count_next = count_reg + CW'(1);
                        end
                    end
                    apq_pkg::KIND_REM_MAX: begin
                        if (empty) begin
                            status_next = apq_pkg::STAT_EMPTY;
                        end else begin
                            out_id_next   = id_w[0];
                            out_prio_next = prio_w[0];
                            count_next    = count_reg - CW'(1);
                        end
                    end
                    apq_pkg::KIND_REM_ID: begin
                        if (empty) begin
                            status_next = apq_pkg::STAT_EMPTY;
                        end else if (!found) begin
                            status_next = apq_pkg::STAT_NOT_FOUND;
                        end else begin
                            out_id_next   = seli_w[DEPTH];
                            out_prio_next = selp_w[DEPTH];
                            count_next    = count_reg - CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
                occ_next = count_next;
            end
            default: begin
                state_next = apq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= apq_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= apq_pkg::apq_kind_t'(s_kind);
            id_reg   <= s_entry_id;
            prio_reg <= s_prio;
        end
        out_id_reg   <= out_id_next;
        out_prio_reg <= out_prio_next;
        status_reg   <= status_next;
        occ_reg      <= occ_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_id    = out_id_reg;
    assign m_out_prio  = out_prio_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("fill count exceeds depth");

    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> ##2 m_valid)
        else $error("result missing two cycles after transaction");

    a_occ_tracks_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_occupancy == count_reg))
        else $error("reported occupancy differs from fill count");
`endif

endmodule

/* rtl/core/apq_cell.sv */
module apq_cell #(
    parameter int IDX     = 0,
    parameter int DEPTH   = apq_pkg::DEPTH_DEF,
    parameter int ID_BITS = apq_pkg::ID_BITS_DEF,
    localparam int CW     = $clog2(DEPTH + 1)
) (
    input  logic                               aclk,
    input  apq_pkg::apq_ctrl_t                 ctrl,
    input  logic [CW-1:0]                      count,
    input  logic [ID_BITS-1:0]                 key_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  key_prio,
    input  logic [ID_BITS-1:0]                 new_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  new_prio,
    input  logic                               left_ge,
    input  logic [ID_BITS-1:0]                 left_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  left_prio,
    input  logic [ID_BITS-1:0]                 right_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  right_prio,
    input  logic                               pass_in,
    input  logic [ID_BITS-1:0]                 sel_in_id,
    input  logic signed [apq_pkg::PRIO_W-1:0]  sel_in_prio,
    output logic                               ge,
    output logic [ID_BITS-1:0]                 cur_id,
    output logic signed [apq_pkg::PRIO_W-1:0]  cur_prio,
    output logic                               pass_out,
    output logic [ID_BITS-1:0]                 sel_out_id,
    output logic signed [apq_pkg::PRIO_W-1:0]  sel_out_prio
);

    logic [ID_BITS-1:0]                id_reg, id_next;
    logic signed [apq_pkg::PRIO_W-1:0] prio_reg, prio_next;
    logic                              ge_reg, ge_next;
    logic                              match_reg, match_next;
    logic                              occ;
    logic                              first_hit;

    assign occ       = count > CW'(IDX);
    assign ge        = ge_reg;
    assign cur_id    = id_reg;
    assign cur_prio  = prio_reg;
    assign pass_out  = pass_in | match_reg;
    assign first_hit = match_reg & ~pass_in;
    assign sel_out_id   = sel_in_id | (first_hit ? id_reg : '0);
    assign sel_out_prio = sel_in_prio | (first_hit ? prio_reg : '0);

    always_comb begin
        ge_next    = ge_reg;
        match_next = match_reg;
        id_next    = id_reg;
        prio_next  = prio_reg;
        if (ctrl.sample) begin
            ge_next    = occ && (prio_reg >= key_prio);
            match_next = occ && (id_reg == key_id);
        end
        if (ctrl.upd) begin
            case (ctrl.kind)
                apq_pkg::KIND_INSERT: begin
                    if (!ge_reg) begin
                        if (left_ge) begin
                            id_next   = new_id;
                            prio_next = new_prio;
                        end else begin
                            id_next   = left_id;
                            prio_next = left_prio;
                        end
                    end
                end
                apq_pkg::KIND_REM_MAX: begin
                    id_next   = right_id;
                    prio_next = right_prio;
                end
                apq_pkg::KIND_REM_ID: begin
                    if (pass_out) begin
                        id_next   = right_id;
                        prio_next = right_prio;
                    end
                end
                apq_pkg::KIND_AGE: begin
                    if (occ && prio_reg != apq_pkg::PRIO_MAX) begin
                        prio_next = prio_reg + 16'sd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        ge_reg    <= ge_next;
        match_reg <= match_next;
        id_reg    <= id_next;
        prio_reg  <= prio_next;
    end

endmodule

/* tb/apq_checker.sv */
module apq_checker
    import apq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [1:0]               s_kind,
    input  logic [7:0]               s_entry_id,
    input  logic signed [PRIO_W-1:0] s_prio,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [7:0]               m_out_id,
    input  logic signed [PRIO_W-1:0] m_out_prio,
    input  logic [1:0]               m_status,
    input  logic [4:0]               m_occupancy,
    output int                       fail_count,
    output int                       pending
);

    localparam int DEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [7:0]               id;
        logic signed [PRIO_W-1:0] prio;
        apq_status_t              status;
        logic [4:0]               occupancy;
    } queue_result_t;

    logic signed [PRIO_W-1:0] held_prio [DEPTH];
    logic [7:0]               held_id   [DEPTH];
    int                       held_count;
    queue_result_t            expected_results [$];

    function automatic void take_out(int pos);
        for (int i = pos; i + 1 < held_count; i++) begin
            held_prio[i] = held_prio[i + 1];
            held_id[i]   = held_id[i + 1];
        end
        held_count--;
    endfunction

    function automatic queue_result_t apply_queue_op(apq_kind_t op, logic [7:0] id,
                                                     logic signed [PRIO_W-1:0] prio);
        queue_result_t r;
        int pos;
        r = '0;
        case (op)
            KIND_INSERT: begin
                if (held_count >= DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_prio[pos] >= prio) pos++;
                    for (int i = held_count; i > pos; i--) begin
                        held_prio[i] = held_prio[i - 1];
                        held_id[i]   = held_id[i - 1];
                    end
                    held_prio[pos] = prio;
                    held_id[pos]   = id;
                    held_count++;
                end
            end
            KIND_REM_MAX: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    r.id   = held_id[0];
                    r.prio = held_prio[0];
                    take_out(0);
                end
            end
            KIND_REM_ID: begin
                if (held_count == 0) begin
                    r.status = STAT_EMPTY;
                end else begin
                    pos = 0;
                    while (pos < held_count && held_id[pos] != id) pos++;
                    if (pos >= held_count) begin
                        r.status = STAT_NOT_FOUND;
                    end else begin
                        r.id   = held_id[pos];
                        r.prio = held_prio[pos];
                        take_out(pos);
                    end
                end
            end
            default: begin
                // age: saturate at the top, order is kept as is
                for (int i = 0; i < held_count; i++)
                    if (held_prio[i] != PRIO_MAX) held_prio[i] = held_prio[i] + 16'sd1;
            end
        endcase
        r.occupancy = 5'(held_count);
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            held_count = 0;
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result transaction id=%0d prio=%0d status=%0d occ=%0d",
                             $time, m_out_id, m_out_prio, m_status, m_occupancy);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_out_id !== want.id || m_out_prio !== want.prio ||
                        m_status !== want.status || m_occupancy !== want.occupancy) begin
                        $display("%0t: mismatch expected id=%0d prio=%0d status=%0d occ=%0d, actual id=%0d prio=%0d status=%0d occ=%0d",
                                 $time, want.id, want.prio, want.status, want.occupancy,
                                 m_out_id, m_out_prio, m_status, m_occupancy);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(apply_queue_op(apq_kind_t'(s_kind), s_entry_id, s_prio));
            pending <= expected_results.size();
        end
    end

endmodule

/* tb/tb.sv */
module tb;
    import apq_pkg::*;

    localparam int NUM_RANDOM  = 750;
    localparam int CYCLE_LIMIT = 200000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [1:0]               s_kind = KIND_INSERT;
    logic [7:0]               s_entry_id = '0;
    logic signed [PRIO_W-1:0] s_prio = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [7:0]               m_out_id;
    logic signed [PRIO_W-1:0] m_out_prio;
    logic [1:0]               m_status;
    logic [4:0]               m_occupancy;
    int                       fail_count;
    int                       pending;
    int                       cycle_count = 0;
    logic                     steady = 1'b0;

    aging_priority_queue DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_entry_id  (s_entry_id),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_id    (m_out_id),
        .m_out_prio  (m_out_prio),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

    apq_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_entry_id  (s_entry_id),
        .s_prio      (s_prio),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_id    (m_out_id),
        .m_out_prio  (m_out_prio),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            m_ready <= steady || ($urandom_range(99) >= 6);
            @(posedge aclk);
        end
    end

    task automatic send_op(apq_kind_t op, logic [7:0] id, logic signed [PRIO_W-1:0] prio);
        if (!steady && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 50);
        end
        s_valid    <= 1'b1;
        s_kind     <= op;
        s_entry_id <= id;
        s_prio     <= prio;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic apq_kind_t pick_kind(int n);
        int roll;
        roll = $urandom_range(99);
        case ((n / 60) % 3)
            0:       return roll < 55 ? KIND_INSERT : roll < 70 ? KIND_REM_MAX :
                            roll < 85 ? KIND_REM_ID : KIND_AGE;
            1:       return roll < 20 ? KIND_INSERT : roll < 55 ? KIND_REM_MAX :
                            roll < 85 ? KIND_REM_ID : KIND_AGE;
            default: return roll < 35 ? KIND_INSERT : roll < 60 ? KIND_REM_MAX :
                            roll < 85 ? KIND_REM_ID : KIND_AGE;
        endcase
    endfunction

    function automatic logic signed [PRIO_W-1:0] pick_prio();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom_range(8) - 4;
            4, 5:       v = 32767 - $urandom_range(6);
            6:          v = -32768 + $urandom_range(3);
            default:    v = $urandom_range(65535);
        endcase
        return v[PRIO_W-1:0];
    endfunction

    initial begin
        logic signed [PRIO_W-1:0] fill_prio [16] = '{
            16'sd32767, 16'sd32766, -16'sd32768, 16'sd0, 16'sd0, 16'sd5, -16'sd1, 16'sd1,
            16'sd100, -16'sd100, 16'sd32767, 16'sd0, -16'sd32768, 16'sd7, 16'sd7, 16'sd16384};
        logic [7:0] fill_id [16] = '{
            8'hFF, 8'h01, 8'h00, 8'hAA, 8'h55, 8'hAA, 8'h02, 8'h03,
            8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B};
        apq_kind_t op;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_op(KIND_REM_MAX, 8'h00, 16'sd0);
        send_op(KIND_REM_ID, 8'h33, 16'sd0);
        send_op(KIND_AGE, 8'h00, 16'sd0);
        for (int i = 0; i < 16; i++) send_op(KIND_INSERT, fill_id[i], fill_prio[i]);
        send_op(KIND_INSERT, 8'h0C, 16'sd0);
        send_op(KIND_AGE, 8'h00, 16'sd0);
        send_op(KIND_AGE, 8'h00, 16'sd0);
        send_op(KIND_REM_ID, 8'h12, 16'sd0);
        send_op(KIND_REM_ID, 8'hAA, 16'sd0);
        send_op(KIND_REM_MAX, 8'h00, 16'sd0);

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n == 300 || n == 600) drain_results();
            steady = (n >= 400 && n < 550);
            op = pick_kind(n);
            send_op(op, $urandom_range(99) < 80 ? 8'($urandom_range(15)) : 8'($urandom_range(255)),
                    pick_prio());
        end
        steady = 1'b0;

        drain_results();
        repeat (6) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/apq_pkg.sv
rtl/core/apq_cell.sv
rtl/core/aging_priority_queue.sv
tb/apq_checker.sv
tb/tb.sv
